// ===== src/assert_macros.svh =====
// assertion macros shared by the draw engine rtl
// every macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true on a clock edge out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/pfde_pkg.sv =====
// types and constants of the page frame buffer draw engine
// no dependencies
package pfde_pkg;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLR   = 2'd0,
    ST_IDLE  = 2'd1,
    ST_RUN   = 2'd2,
    ST_DRAIN = 2'd3
  } state_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS    = 2'd1;

  localparam logic [7:0] ACTIVE_COLUMNS_RST = 8'd128;
  localparam logic [6:0] ACTIVE_ROWS_RST    = 7'd64;

  // control of the write-back stage of one column byte
  typedef struct packed {
    logic       valid;
    logic       clear;
    logic       col_hit;
    logic       color;
    logic [7:0] row_base;
    logic [7:0] y;
    logic [7:0] h;
    logic [6:0] active_rows;
  } rmw_ctl_t;

endpackage

// ===== src/pfde_if.sv =====
// command and result channel interfaces of the draw engine
// no dependencies
interface pfde_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] rect_w;
  logic [7:0] rect_h;
  logic       color;

  modport source (output valid, mode, x, y, rect_w, rect_h, color, input ready);
  modport sink (input valid, mode, x, y, rect_w, rect_h, color, output ready);
endinterface

interface pfde_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       was_read;

  modport source (output valid, read_data, was_read, input ready);
  modport sink (input valid, read_data, was_read, output ready);
endinterface

// ===== src/page_framebuffer_draw_engine.sv =====
// page frame buffer draw engine: pixel, rectangle fill, clear all, byte read
// pixel and read: a single byte is addressed; a new command waits until the result is loaded
// fill, clear: every byte is walked in turn; a new command waits until the result is loaded
// reset: clearing pass over all COLUMNS*PAGES bytes with in ready low, then idle
// depends on pfde_pkg, pfde_if, pfde_ram, pfde_rmw, assert_macros.svh
`include "assert_macros.svh"

module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pfde_cmd_if.sink             in_chan,
  pfde_res_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned AW    = PW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

  state_t state_r, state_nxt;

  logic [7:0]    active_cols_r, active_cols_nxt;
  logic [6:0]    active_rows_r, active_rows_nxt;

  mode_t         mode_r, mode_nxt;
  logic [7:0]    x_r, x_nxt;
  logic [7:0]    y_r, y_nxt;
  logic [7:0]    w_r, w_nxt;
  logic [7:0]    h_r, h_nxt;
  logic          color_r, color_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          single_r, single_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          vb_r, vb_nxt;
  logic          clear_b_r, clear_b_nxt;
  logic          col_hit_b_r, col_hit_b_nxt;
  logic [PW-1:0] page_b_r, page_b_nxt;
  logic [CW-1:0] col_b_r, col_b_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_rd_r, out_rd_nxt;

  logic          accept;
  logic          issue;
  logic          last;
  logic          clear_a;
  logic          out_load;
  logic          col_hit_a;
  logic          x_in;
  logic          page_in;
  mode_t         in_mode;

  rmw_ctl_t      rmw_ctl;
  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign in_mode = mode_t'(in_chan.mode);
  assign accept  = in_chan.valid && in_chan.ready;
  assign last    = single_r || ((col_r == COL_LAST) && (page_r == PAGE_LAST));
  assign x_in    = {1'b0, in_chan.x} < 9'(COLUMNS);
  assign page_in = in_chan.y[7:3] < 5'(PAGES);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    issue         = 1'b0;
    out_load      = 1'b0;
    clear_a       = 1'b0;
    case (state_r)
      ST_CLR: begin
        issue   = 1'b1;
        clear_a = 1'b1;
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      ST_RUN: begin
        issue   = 1'b1;
        clear_a = (mode_r == MODE_CLEAR);
      end
      ST_DRAIN: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  assign col_hit_a = ((8'(col_r) - x_r) < w_r) && (8'(col_r) < active_cols_r);

  // command latch, address counter and write-back stage
  always_comb begin
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    color_nxt     = color_r;
    rd_ok_nxt     = rd_ok_r;
    single_nxt    = single_r;
    page_nxt      = page_r;
    col_nxt       = col_r;
    if (accept) begin
      mode_nxt   = in_mode;
      x_nxt      = in_chan.x;
      y_nxt      = in_chan.y;
      color_nxt  = in_chan.color;
      rd_ok_nxt  = x_in && page_in;
      single_nxt = (in_mode == MODE_PIXEL) || (in_mode == MODE_READ);
      case (in_mode)
        MODE_PIXEL: begin
          w_nxt    = (x_in && page_in) ? 8'd1 : 8'd0;
          h_nxt    = 8'd1;
          col_nxt  = in_chan.x[CW-1:0];
          page_nxt = PW'(in_chan.y[7:3]);
        end
        MODE_FILL: begin
          w_nxt    = in_chan.rect_w;
          h_nxt    = in_chan.rect_h;
          col_nxt  = '0;
          page_nxt = '0;
        end
        MODE_READ: begin
          w_nxt    = 8'd0;
          h_nxt    = 8'd0;
          col_nxt  = in_chan.x[CW-1:0];
          page_nxt = PW'(in_chan.y[7:3]);
        end
        default: begin
          w_nxt    = 8'd0;
          h_nxt    = 8'd0;
          col_nxt  = '0;
          page_nxt = '0;
        end
      endcase
    end else if (issue && !last) begin
      if (col_r == COL_LAST) begin
        col_nxt  = '0;
        page_nxt = page_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    vb_nxt        = issue;
    clear_b_nxt   = clear_a;
    col_hit_b_nxt = col_hit_a;
    page_b_nxt    = page_r;
    col_b_nxt     = col_r;
  end

  // configuration and result register
  always_comb begin
    active_cols_nxt = active_cols_r;
    active_rows_nxt = active_rows_r;
    if (cfg_we && (cfg_index == CFG_ACTIVE_COLUMNS)) begin
      active_cols_nxt = cfg_data;
    end
    if (cfg_we && (cfg_index == CFG_ACTIVE_ROWS)) begin
      active_rows_nxt = cfg_data[6:0];
    end

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    out_rd_nxt    = out_rd_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = (mode_r == MODE_READ);
      out_data_nxt  = ((mode_r == MODE_READ) && rd_ok_r) ? ram_rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      active_cols_r <= ACTIVE_COLUMNS_RST;
      active_rows_r <= ACTIVE_ROWS_RST;
      single_r      <= 1'b0;
      page_r        <= '0;
      col_r         <= '0;
      vb_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      active_cols_r <= active_cols_nxt;
      active_rows_r <= active_rows_nxt;
      single_r      <= single_nxt;
      page_r        <= page_nxt;
      col_r         <= col_nxt;
      vb_r          <= vb_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    color_r     <= color_nxt;
    rd_ok_r     <= rd_ok_nxt;
    clear_b_r   <= clear_b_nxt;
    col_hit_b_r <= col_hit_b_nxt;
    page_b_r    <= page_b_nxt;
    col_b_r     <= col_b_nxt;
    out_data_r  <= out_data_nxt;
    out_rd_r    <= out_rd_nxt;
  end

  assign rmw_ctl = '{
    valid:       vb_r,
    clear:       clear_b_r,
    col_hit:     col_hit_b_r,
    color:       color_r,
    row_base:    8'({page_b_r, 3'b000}),
    y:           y_r,
    h:           h_r,
    active_rows: active_rows_r
  };

  pfde_rmw u_rmw (
    .ctl   (rmw_ctl),
    .rdata (ram_rdata),
    .we    (ram_we),
    .wdata (ram_wdata)
  );

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({page_b_r, col_b_r}),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr ({page_r, col_r}),
    .rdata (ram_rdata)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.was_read  = out_rd_r;

  `ASSERT_CLK(a_ready_pipe_empty, in_chan.ready |-> !vb_r || clear_b_r, "ready while a byte is in write-back")
  `ASSERT_CLK(a_accept_busy, accept |=> !in_chan.ready, "ready did not drop after a command")
  `ASSERT_NEVER(a_no_overwrite, out_load && out_valid_r && !out_chan.ready,
                "result register overwritten before it was taken")
  `ASSERT_NEVER(a_write_idle, ram_we && (state_r == ST_IDLE) && !vb_r,
                "store written with no byte in write-back")

endmodule

// ===== src/pfde_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module pfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pfde_rmw.sv =====
// write-back stage: builds the row mask of one column byte and merges it, or writes zero when clearing
// depends on pfde_pkg
module pfde_rmw
  import pfde_pkg::*;
(
  input  rmw_ctl_t   ctl,
  input  logic [7:0] rdata,
  output logic       we,
  output logic [7:0] wdata
);

  logic [7:0] mask;
  logic [7:0] row;
  logic [7:0] row_off;

  always_comb begin
    mask    = '0;
    row     = '0;
    row_off = '0;
    for (int n = 0; n < 8; n++) begin
      row     = ctl.row_base | 8'(n);
      row_off = row - ctl.y;
      mask[n] = (row_off < ctl.h) && (row < {1'b0, ctl.active_rows});
    end
  end

  always_comb begin
    we = ctl.valid && (ctl.clear || (ctl.col_hit && (mask != 8'd0)));
    if (ctl.clear) begin
      wdata = 8'd0;
    end else if (ctl.color) begin
      wdata = rdata | mask;
    end else begin
      wdata = rdata & ~mask;
    end
  end

endmodule
